// ===== src/tqtd_pkg.sv =====
// ============================================================================
// tqtd_pkg
// Shared types, constants and helpers of the tick-driven tail-drop queue.
// ============================================================================
package tqtd_pkg;

    localparam int QUEUE_DEPTH = 1024;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int GAP_W   = 24;
    localparam int SVC_W   = 24;
    localparam int CAP_W   = 11;
    localparam int OCC_W   = 11;
    localparam int CNT_W   = 32;
    localparam int LIM_W   = (FILL_W > CAP_W) ? FILL_W : CAP_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SERVICE_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNLIMITED     = 2'd2;

    localparam logic [SVC_W-1:0] SVC_RESET = SVC_W'(1);
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

    typedef struct packed {
        logic [GAP_W-1:0] next_gap;
        logic             end_of_run;
    } in_item_t;

    typedef struct packed {
        logic [OCC_W-1:0] occupancy;
        logic             idle;
        logic             arrived;
        logic             dropped;
        logic             departed;
        logic [CNT_W-1:0] sojourn_ticks;
        logic [CNT_W-1:0] tick_index;
        logic [CNT_W-1:0] dropped_total;
        logic [CNT_W-1:0] idle_total;
        logic [CNT_W-1:0] created_total;
        logic             run_done;
    } out_item_t;

    typedef struct packed {
        logic [SVC_W-1:0] service_ticks;
        logic [CAP_W-1:0] capacity;
        logic             unlimited;
    } cfg_t;

    // Stamp store access for one tick
    typedef struct packed {
        logic             wr_en;
        logic [PTR_W-1:0] wr_addr;
        logic [CNT_W-1:0] wr_data;
        logic             rd_en;
        logic [PTR_W-1:0] rd_addr;
    } store_req_t;

    // Tick result before the sojourn time is known
    typedef struct packed {
        out_item_t item;
        logic      same_tick;
    } tick_res_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v,
                                                 input logic            en);
        logic [CNT_W-1:0] r;
        r = v;
        if (en && (v != {CNT_W{1'b1}}))
        begin
            r = v + CNT_W'(1);
        end
        return r;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

endpackage

// ===== src/tqtd_stamp_store.sv =====
// ============================================================================
// tqtd_stamp_store
// Arrival stamp memory: one write port, one registered read port.
// ============================================================================
module tqtd_stamp_store (
    input  logic                        clk,
    input  tqtd_pkg::store_req_t        req,
    output logic [tqtd_pkg::CNT_W-1:0]  rd_data
);
    import tqtd_pkg::*;

    logic [CNT_W-1:0] mem [QUEUE_DEPTH];

    // Read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

// ===== src/tqtd_tick_ctrl.sv =====
// ============================================================================
// tqtd_tick_ctrl
// Per-tick queue state: arrival countdown, tail drop, service and counters.
// ============================================================================
module tqtd_tick_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tick_en,
    input  tqtd_pkg::in_item_t    item,
    input  tqtd_pkg::cfg_t        cfg,
    output tqtd_pkg::tick_res_t   res,
    output tqtd_pkg::store_req_t  store_req
);
    import tqtd_pkg::*;

    logic             gap_loaded_reg,   gap_loaded_next;
    logic [GAP_W-1:0] countdown_reg,    countdown_next;
    logic [CNT_W-1:0] tick_reg,         tick_next;
    logic [SVC_W-1:0] head_served_reg,  head_served_next;
    logic [FILL_W-1:0] fill_reg,        fill_next;
    logic [PTR_W-1:0] rd_ptr_reg,       rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg,       wr_ptr_next;
    logic [CNT_W-1:0] drop_cnt_reg,     drop_cnt_next;
    logic [CNT_W-1:0] idle_cnt_reg,     idle_cnt_next;
    logic [CNT_W-1:0] created_cnt_reg,  created_cnt_next;

    logic [GAP_W-1:0]  gap_val;
    logic [GAP_W-1:0]  cd_start;
    logic [GAP_W-1:0]  cd_dec;
    logic [CNT_W-1:0]  created_mid;
    logic [LIM_W-1:0]  limit;
    logic              arrive;
    logic              drop;
    logic              push;
    logic [FILL_W-1:0] fill_arr;
    logic              idle;
    logic [SVC_W-1:0]  svc;
    logic [SVC_W-1:0]  served_inc;
    logic              depart;

    always_comb
    begin
        gap_val     = (item.next_gap == '0) ? GAP_W'(1) : item.next_gap;
        tick_next   = tick_reg + CNT_W'(1);

        // Load the countdown on the first tick, then count it down
        cd_start    = gap_loaded_reg ? countdown_reg : gap_val;
        created_mid = sat_inc(created_cnt_reg, !gap_loaded_reg);
        cd_dec      = cd_start - GAP_W'(1);
        arrive      = (cd_dec == '0);

        // Tail drop against capacity or the store depth
        if (cfg.unlimited || (LIM_W'(cfg.capacity) >= LIM_W'(QUEUE_DEPTH)))
        begin
            limit = LIM_W'(QUEUE_DEPTH);
        end
        else
        begin
            limit = LIM_W'(cfg.capacity);
        end
        drop     = arrive && (LIM_W'(fill_reg) >= limit);
        push     = arrive && !drop;
        fill_arr = fill_reg + FILL_W'(push);

        // Serve the head packet
        idle       = (fill_arr == '0);
        svc        = (cfg.service_ticks == '0) ? SVC_W'(1) : cfg.service_ticks;
        served_inc = head_served_reg + SVC_W'(1);
        depart     = !idle && (served_inc >= svc);

        gap_loaded_next  = 1'b1;
        countdown_next   = arrive ? gap_val : cd_dec;
        created_cnt_next = sat_inc(created_mid, arrive);
        drop_cnt_next    = sat_inc(drop_cnt_reg, drop);
        idle_cnt_next    = sat_inc(idle_cnt_reg, idle);
        head_served_next = idle ? head_served_reg : (depart ? '0 : served_inc);
        fill_next        = fill_arr - FILL_W'(depart);
        wr_ptr_next      = push ? ptr_next(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next      = depart ? ptr_next(rd_ptr_reg) : rd_ptr_reg;
    end

    always_comb
    begin
        store_req.wr_en   = tick_en && push;
        store_req.wr_addr = wr_ptr_reg;
        store_req.wr_data = tick_next;
        store_req.rd_en   = tick_en;
        store_req.rd_addr = rd_ptr_reg;

        res.item.occupancy     = OCC_W'(fill_arr);
        res.item.idle          = idle;
        res.item.arrived       = arrive;
        res.item.dropped       = drop;
        res.item.departed      = depart;
        res.item.sojourn_ticks = '0;
        res.item.tick_index    = tick_next;
        res.item.dropped_total = drop_cnt_next;
        res.item.idle_total    = idle_cnt_next;
        res.item.created_total = created_cnt_next;
        res.item.run_done      = item.end_of_run;
        // Head written this very tick: the read sees stale data
        res.same_tick          = push && (fill_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_loaded_reg  <= 1'b0;
            countdown_reg   <= '0;
            tick_reg        <= '0;
            head_served_reg <= '0;
            fill_reg        <= '0;
            rd_ptr_reg      <= '0;
            wr_ptr_reg      <= '0;
            drop_cnt_reg    <= '0;
            idle_cnt_reg    <= '0;
            created_cnt_reg <= '0;
        end
        else if (tick_en)
        begin
            gap_loaded_reg  <= gap_loaded_next;
            countdown_reg   <= countdown_next;
            tick_reg        <= tick_next;
            head_served_reg <= head_served_next;
            fill_reg        <= fill_next;
            rd_ptr_reg      <= rd_ptr_next;
            wr_ptr_reg      <= wr_ptr_next;
            drop_cnt_reg    <= drop_cnt_next;
            idle_cnt_reg    <= idle_cnt_next;
            created_cnt_reg <= created_cnt_next;
        end
    end

endmodule

// ===== src/tick_queue_tail_drop_model_top.sv =====
// ============================================================================
// tick_queue_tail_drop_model_top
// Tick-driven single-server queue with tail drop and arrival time stamps.
// Pipeline: two register stages; a tick's result passes through stage 1 and
// then the output register, where it is held until the consumer takes it.
// Throughput: one tick per cycle while the consumer takes results; the stamp
// memory has one write and one read port, and each tick uses each at most once.
// Reset: counters, pointers and pipeline valids clear at once; the stamp
// memory is not cleared, since only data from written entries is ever used.
// ============================================================================
module tick_queue_tail_drop_model_top (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  tqtd_pkg::in_item_t              in_item,

    output logic                            out_valid,
    input  logic                            out_ready,
    output tqtd_pkg::out_item_t             out_item,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tqtd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tqtd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tqtd_pkg::*;

    // Configuration registers
    cfg_t       cfg_reg;

    // Stage 1: tick evaluated, stamp read in flight
    logic       s1_valid_reg;
    tick_res_t  s1_res_reg;

    // Output register
    logic       out_valid_reg;
    out_item_t  out_item_reg;

    tick_res_t        tick_res;
    store_req_t       store_req;
    logic [CNT_W-1:0] stamp;
    logic             in_fire;
    logic             out_free;
    logic             s1_move;
    out_item_t        s1_item;

    // Configuration writes are always accepted and registered; unknown indexes are ignored
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.service_ticks <= SVC_RESET;
            cfg_reg.capacity      <= CAP_RESET;
            cfg_reg.unlimited     <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SERVICE_TICKS: cfg_reg.service_ticks <= SVC_W'(cfg_data);
                CFG_CAPACITY:      cfg_reg.capacity      <= CAP_W'(cfg_data);
                CFG_UNLIMITED:     cfg_reg.unlimited     <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Handshake chain: advance stage 1 when the output register frees up,
    // accept a new tick when stage 1 is empty or advancing.
    assign out_free = !out_valid_reg || out_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;
    assign in_fire  = in_valid && in_ready;

    tqtd_tick_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick_en   (in_fire),
        .item      (in_item),
        .cfg       (cfg_reg),
        .res       (tick_res),
        .store_req (store_req)
    );

    // The read port is enabled only on accepted ticks, so its data holds
    // while stage 1 is stalled.
    tqtd_stamp_store u_store (
        .clk     (clk),
        .req     (store_req),
        .rd_data (stamp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_res_reg <= tick_res;
        end
    end

    // Sojourn: departure tick minus the head's stamp. A head stamped on the
    // same tick bypasses the memory and departs with zero.
    always_comb
    begin
        s1_item = s1_res_reg.item;
        if (s1_res_reg.item.departed && !s1_res_reg.same_tick)
        begin
            s1_item.sojourn_ticks = s1_res_reg.item.tick_index - stamp;
        end
        else
        begin
            s1_item.sojourn_ticks = '0;
        end
    end

    // Hold the result until the consumer takes the transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_item_reg <= s1_item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== dv/tick_queue_tail_drop_model_top_tb.sv =====
// ============================================================================
// tick_queue_tail_drop_model_top_tb
// Self-checking bench for the tick-driven tail-drop queue. A short scripted
// sequence walks the corner cases, then randomized phases with changing queue
// settings run against a cycle-free model of the queue kept in the bench.
// ============================================================================
module tick_queue_tail_drop_model_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tqtd_pkg::*;

    // Spare register slot: writes to it must leave every setting alone
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int IDLE_PCT    = 29;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 5000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_item;
    logic                  out_valid;
    logic                  out_ready;
    out_item_t             out_item;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // One scripted step: either a register write or a tick transaction
    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        in_item_t              tick;
        bit                    typed;
        out_item_t             want;
    } script_row_t;

    script_row_t script[$];

    // Tick reports still owed by the block, oldest first
    out_item_t owed_reports[$];
    out_item_t head_report;

    // Queue model: settings
    logic [SVC_W-1:0] svc_reg;
    logic [CAP_W-1:0] cap_reg;
    logic             unl_reg;

    // Queue model: state
    bit               gap_armed;
    logic [GAP_W-1:0] arrive_cnt;
    logic [CNT_W-1:0] tick_no;
    logic [SVC_W-1:0] head_ticks;
    int               depth_used;
    logic [PTR_W-1:0] rd_slot;
    logic [PTR_W-1:0] wr_slot;
    logic [CNT_W-1:0] stamp_mem [QUEUE_DEPTH];
    logic [CNT_W-1:0] tot_drop;
    logic [CNT_W-1:0] tot_idle;
    logic [CNT_W-1:0] tot_gaps;

    int mismatches  = 0;
    int quiet_cycles = 0;
    bit steady      = 1'b0;
    bit hold_req    = 1'b0;
    bit ticks_open  = 1'b0;

    tick_queue_tail_drop_model_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Queue model
    // ------------------------------------------------------------------------

    // Saturating running count
    function automatic logic [CNT_W-1:0] bump_count(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

    // Take a fresh interarrival gap; zero counts as one tick
    function automatic logic [GAP_W-1:0] draw_gap(input logic [GAP_W-1:0] g);
        tot_gaps = bump_count(tot_gaps);
        return (g == '0) ? GAP_W'(1) : g;
    endfunction

    // Advance the model by one tick and return the report it produces
    function automatic out_item_t advance_tick(input in_item_t it);
        out_item_t        r;
        int               lim;
        logic [SVC_W-1:0] svc_eff;
        r = '0;
        tick_no = tick_no + CNT_W'(1);
        if (!gap_armed)
        begin
            arrive_cnt = draw_gap(it.next_gap);
            gap_armed  = 1'b1;
        end
        arrive_cnt = arrive_cnt - GAP_W'(1);
        if (arrive_cnt == '0)
        begin
            r.arrived = 1'b1;
            // Limited mode honors capacity, but never beyond the store
            lim = QUEUE_DEPTH;
            if (!unl_reg && int'(cap_reg) < lim)
            begin
                lim = int'(cap_reg);
            end
            if (depth_used >= lim)
            begin
                r.dropped = 1'b1;
                tot_drop  = bump_count(tot_drop);
            end
            else
            begin
                stamp_mem[wr_slot] = tick_no;
                wr_slot    = ptr_next(wr_slot);
                depth_used = depth_used + 1;
            end
            arrive_cnt = draw_gap(it.next_gap);
        end
        r.occupancy = OCC_W'(depth_used);
        if (depth_used == 0)
        begin
            r.idle   = 1'b1;
            tot_idle = bump_count(tot_idle);
        end
        else
        begin
            // Compare against the current setting, so a rewrite mid-service
            // releases the head as soon as it has served enough
            svc_eff    = (svc_reg == '0) ? SVC_W'(1) : svc_reg;
            head_ticks = head_ticks + SVC_W'(1);
            if (head_ticks >= svc_eff)
            begin
                r.departed      = 1'b1;
                r.sojourn_ticks = tick_no - stamp_mem[rd_slot];
                rd_slot    = ptr_next(rd_slot);
                depth_used = depth_used - 1;
                head_ticks = '0;
            end
        end
        r.tick_index    = tick_no;
        r.dropped_total = tot_drop;
        r.idle_total    = tot_idle;
        r.created_total = tot_gaps;
        r.run_done      = it.end_of_run;
        return r;
    endfunction

    // Pick a tick payload. On ticks that load a gap keep it within gap_hi so
    // arrivals keep coming; elsewhere the gap is ignored, so use any value.
    function automatic in_item_t draw_tick(input int gap_hi);
        in_item_t it;
        it.end_of_run = ($urandom_range(0, 15) == 0);
        if (!gap_armed || arrive_cnt == GAP_W'(1))
        begin
            it.next_gap = ($urandom_range(0, 9) == 0) ? '0 : GAP_W'($urandom_range(1, gap_hi));
        end
        else
        begin
            it.next_gap = GAP_W'($urandom());
        end
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Drop input valid and hold until every owed report is back, then let the
    // two-stage pipeline settle before touching a register
    task automatic drain();
        in_valid <= 1'b0;
        while (owed_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        ticks_open = 1'b0;
    endtask

    // Offer one tick transaction, idling cycle by cycle at random first
    task automatic send_tick(input in_item_t it, input bit typed, input out_item_t want);
        out_item_t pred;
        cfg_valid <= 1'b0;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        pred = advance_tick(it);
        owed_reports.insert(owed_reports.size(), typed ? want : pred);
        ticks_open = 1'b1;
    endtask

    // Write one register; the block is always brought to rest first
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        if (ticks_open)
        begin
            drain();
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        case (idx)
            CFG_SERVICE_TICKS: svc_reg = data[SVC_W-1:0];
            CFG_CAPACITY:      cap_reg = data[CAP_W-1:0];
            CFG_UNLIMITED:     unl_reg = data[0];
            default:           ;
        endcase
    endtask

    // Write all three settings, with junk in the unused upper data bits of the capacity and mode writes
    task automatic set_mode(input logic [SVC_W-1:0] svc, input logic [CAP_W-1:0] cap,
                            input logic unl);
        write_reg(CFG_SERVICE_TICKS, svc);
        write_reg(CFG_CAPACITY, {13'($urandom()), cap});
        write_reg(CFG_UNLIMITED, {23'($urandom()), unl});
    endtask

    function automatic script_row_t tick_row(input logic [GAP_W-1:0] gap, input logic eor);
        script_row_t r;
        r = '{default: '0};
        r.tick.next_gap   = gap;
        r.tick.end_of_run = eor;
        return r;
    endfunction

    function automatic script_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        script_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        return r;
    endfunction

    // Append one row to the script
    function automatic void add_row(input script_row_t r);
        script.insert(script.size(), r);
    endfunction

    // Scripted corner cases, starting from the reset settings
    task automatic fill_script();
        script_row_t first;
        // First tick with a zero gap: it arrives at once, reloads the same
        // gap, and departs on the spot with the reset service of one tick
        first = tick_row('0, 1'b0);
        first.typed              = 1'b1;
        first.want.occupancy     = OCC_W'(1);
        first.want.arrived       = 1'b1;
        first.want.departed      = 1'b1;
        first.want.tick_index    = CNT_W'(1);
        first.want.created_total = CNT_W'(2);
        add_row(first);
        add_row(tick_row(24'd3, 1'b0));
        // Two gaps that are never loaded, with every bit high and alternating,
        // then a zero gap loaded on the next arrival
        add_row(tick_row(24'hFFFFFF, 1'b1));
        add_row(tick_row(24'h555555, 1'b0));
        add_row(tick_row(24'h000000, 1'b0));
        // Limited mode with zero capacity: drop every arrival
        add_row(cfg_row(CFG_SERVICE_TICKS, 24'd3));
        add_row(cfg_row(CFG_CAPACITY, 24'd0));
        add_row(cfg_row(CFG_UNLIMITED, 24'd0));
        add_row(tick_row(24'd1, 1'b0));
        add_row(tick_row(24'd1, 1'b1));
        // Capacity above the store depth: masked to 2047, store depth rules
        add_row(cfg_row(CFG_CAPACITY, 24'hFFFFFF));
        repeat (4) add_row(tick_row(24'd1, 1'b0));
        // Stretch service while a head is part-served, then drop it to zero
        add_row(cfg_row(CFG_SERVICE_TICKS, 24'hFFFFFF));
        add_row(tick_row(24'd2, 1'b0));
        add_row(tick_row(24'hAAAAAA, 1'b1));
        add_row(cfg_row(CFG_SERVICE_TICKS, 24'd0));
        repeat (4) add_row(tick_row(24'd7, 1'b0));
        // Unlimited mode ignores a capacity of one
        add_row(cfg_row(CFG_UNLIMITED, 24'd1));
        add_row(cfg_row(CFG_CAPACITY, 24'd1));
        repeat (3) add_row(tick_row(24'd0, 1'b0));
        // Spare slot write changes nothing
        add_row(cfg_row(CFG_SPARE, 24'hFFFFFF));
        add_row(tick_row(24'd1, 1'b0));
        // Bit zero clear with upper junk: back to limited mode, capacity one
        add_row(cfg_row(CFG_UNLIMITED, 24'hFFFFFE));
        repeat (3) add_row(tick_row(24'd0, 1'b1));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        logic [SVC_W-1:0] svc_pick;
        logic [CAP_W-1:0] cap_pick;
        int               gap_hi;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        svc_reg    = SVC_RESET;
        cap_reg    = CAP_RESET;
        unl_reg    = 1'b1;
        gap_armed  = 1'b0;
        arrive_cnt = '0;
        tick_no    = '0;
        head_ticks = '0;
        depth_used = 0;
        rd_slot    = '0;
        wr_slot    = '0;
        tot_drop   = '0;
        tot_idle   = '0;
        tot_gaps   = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the scripted corner cases
        fill_script();
        foreach (script[i])
        begin
            if (script[i].is_cfg)
            begin
                write_reg(script[i].idx, script[i].data);
            end
            else
            begin
                send_tick(script[i].tick, script[i].typed, script[i].want);
            end
        end

        // Randomized phases with fresh settings each time. Keep arrivals
        // near the service rate so the queue hovers around its limit.
        // Phase one holds the result side off; phase two runs without gaps.
        for (int p = 0; p < 6; p++)
        begin
            svc_pick = SVC_W'($urandom_range(0, 5));
            cap_pick = ($urandom_range(0, 7) == 0) ? CAP_W'(2047) : CAP_W'($urandom_range(0, 6));
            set_mode(svc_pick, cap_pick, 1'($urandom_range(0, 1)));
            gap_hi = $urandom_range(1, 2 * ((svc_pick == '0) ? 1 : int'(svc_pick)) + 2);
            steady = (p == 2);
            if (p == 1)
            begin
                hold_req = 1'b1;
            end
            repeat (90) send_tick(draw_tick(gap_hi), 1'b0, '0);
        end
        steady = 1'b0;

        // Limited mode at full store capacity
        set_mode(SVC_W'(1), CAP_W'(QUEUE_DEPTH), 1'b0);
        repeat (40) send_tick(draw_tick(2), 1'b0, '0);

        drain();
        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random back-pressure, one long hold on request
    // ------------------------------------------------------------------------
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                // Hold ready low long enough to back the block up into its input
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [CNT_W-1:0] want,
                                        input logic [CNT_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Compare each accepted report with the oldest one owed
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (owed_reports.size() == 0)
            begin
                $display("%0t: report with no tick owed, expected none, got tick %0d",
                         $time, out_item.tick_index);
                mismatches++;
            end
            else
            begin
                head_report = owed_reports.pop_front();
                check_field("occupancy",     CNT_W'(head_report.occupancy),
                            CNT_W'(out_item.occupancy));
                check_field("idle",          CNT_W'(head_report.idle),
                            CNT_W'(out_item.idle));
                check_field("arrived",       CNT_W'(head_report.arrived),
                            CNT_W'(out_item.arrived));
                check_field("dropped",       CNT_W'(head_report.dropped),
                            CNT_W'(out_item.dropped));
                check_field("departed",      CNT_W'(head_report.departed),
                            CNT_W'(out_item.departed));
                check_field("sojourn_ticks", head_report.sojourn_ticks, out_item.sojourn_ticks);
                check_field("tick_index",    head_report.tick_index,    out_item.tick_index);
                check_field("dropped_total", head_report.dropped_total, out_item.dropped_total);
                check_field("idle_total",    head_report.idle_total,    out_item.idle_total);
                check_field("created_total", head_report.created_total, out_item.created_total);
                check_field("run_done",      CNT_W'(head_report.run_done),
                            CNT_W'(out_item.run_done));
            end
        end
    end

    // Watchdog: end the run when no transaction of any kind moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
